// ===== rtl/kvt_pkg.sv =====
// Shared types, codes and constants for the key/value table.
package kvt_pkg;

    // Default sizes of the table.
    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 64;

    // Fixed field widths of the stream words.
    localparam int FUNC_W     = 3;
    localparam int KEY_W      = 64;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 136;

    // Bit positions of the input fields inside s_tdata.
    localparam int S_KEY_LSB   = FUNC_W;
    localparam int S_VALUE_LSB = FUNC_W + KEY_W;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_QUERY  = 3'd1,
        FUNC_UPDATE = 3'd2,
        FUNC_DELETE = 3'd3,
        FUNC_LIST   = 3'd4
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 3'd0,
        STATUS_EXISTS    = 3'd1,
        STATUS_NOT_FOUND = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_EMPTY     = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_LIST = 2'd2
    } state_t;

    // Commands broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_UPDATE = 3'd2,
        CELL_DELETE = 3'd3,
        CELL_ROTATE = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;      // what the cells do at this edge
        logic      compare;  // capture the key comparison result
    } cell_ctrl_t;

endpackage

// ===== rtl/kvt_cell.sv =====
// One cell of the table chain: stores a key/value pair and compares its key.
module kvt_cell #(
    parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  kvt_pkg::cell_ctrl_t    ctrl,
    input  logic [CNT_W-1:0]       count,
    input  logic [KEY_BITS-1:0]    cmp_key,
    input  logic [KEY_BITS-1:0]    wr_key,
    input  logic [VALUE_BITS-1:0]  wr_value,
    input  logic [KEY_BITS-1:0]    nb_key,
    input  logic [VALUE_BITS-1:0]  nb_value,
    input  logic [KEY_BITS-1:0]    head_key,
    input  logic [VALUE_BITS-1:0]  head_value,
    input  logic                   hit_in,
    output logic [KEY_BITS-1:0]    key,
    output logic [VALUE_BITS-1:0]  value,
    output logic                   match,
    output logic                   hit_out
);

    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  match_reg, match_next;
    logic                  occupied, is_tail, is_slot;

    assign occupied = CNT_W'(IDX) < count;
    assign is_tail  = CNT_W'(IDX + 1) == count;
    assign is_slot  = CNT_W'(IDX) == count;
    // Set in this cell and in every cell after the matching one.
    assign hit_out  = hit_in | match_reg;

    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        match_next = match_reg;
        if (ctrl.compare) begin
            match_next = occupied && (key_reg == cmp_key);
        end
        case (ctrl.cmd)
            kvt_pkg::CELL_INSERT: begin
                if (is_slot) begin
                    key_next   = wr_key;
                    value_next = wr_value;
                end
            end
            kvt_pkg::CELL_UPDATE: begin
                if (match_reg) begin
                    value_next = wr_value;
                end
            end
            kvt_pkg::CELL_DELETE: begin
                if (hit_out && occupied) begin
                    key_next   = nb_key;
                    value_next = nb_value;
                end
            end
            kvt_pkg::CELL_ROTATE: begin
                if (is_tail) begin
                    key_next   = head_key;
                    value_next = head_value;
                end else if (occupied) begin
                    key_next   = nb_key;
                    value_next = nb_value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

// ===== rtl/key_value_table.sv =====
// Top level of the ordered key/value table with exact key match.
//
// Requests arrive as words on the s_ channel: an operation code, a key and a
// value. Results leave as words on the m_ channel; m_tlast marks the final
// word caused by a request. Insert, query, update, delete and unused codes
// give one word each. List gives one word per stored entry in insertion
// order, or a single word with status empty when nothing is stored.
//
// The table is a chain of cells. At the accepting edge every cell compares
// its key against the request key; in the execute state that follows, the
// controller acts on the match pattern and loads the output register once
// the register is free. A list of N entries then moves to the list state
// and emits one word each time the output register is free: the chain
// rotates by one cell per emitted word, head cell first, and is back in its
// original order after N rotations.
//
// A new request is taken only while the controller is idle. When the
// receiver stalls, the finished word waits in the output register and the
// controller holds until the register is free. Reset empties the table and
// drops any pending word; the stored pairs themselves are not cleared.
module key_value_table #(
    parameter int DEPTH      = kvt_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // func [2:0], key [66:3], value [130:67], zero pad [135:131]
    input  logic [kvt_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [2:0], found_key [66:3], found_value [130:67], count [135:131]
    output logic [kvt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Controller state.
    kvt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] left_reg, left_next;

    // Request held while it is executed.
    logic [kvt_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [KEY_BITS-1:0]        req_key_reg, req_key_next;
    logic [VALUE_BITS-1:0]      req_value_reg, req_value_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [kvt_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [kvt_pkg::KEY_W-1:0]     out_key_reg, out_key_next;
    logic [kvt_pkg::VALUE_W-1:0]   out_value_reg, out_value_next;
    logic [kvt_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_load;
    logic                          out_free;

    // Chain wiring.
    kvt_pkg::cell_ctrl_t    cell_ctrl;
    logic [KEY_BITS-1:0]    cell_key   [DEPTH];
    logic [VALUE_BITS-1:0]  cell_value [DEPTH];
    logic [DEPTH-1:0]       match_vec;
    logic [DEPTH:0]         hit_chain;
    logic                   any_hit;
    logic [VALUE_BITS-1:0]  hit_value;
    logic                   s_accept;
    logic [KEY_BITS-1:0]    s_key;

    assign s_accept = s_tvalid && s_tready;
    assign s_key    = s_tdata[kvt_pkg::S_KEY_LSB +: KEY_BITS];
    assign out_free = !out_valid_reg || m_tready;

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_BITS-1:0]   nb_key;
        logic [VALUE_BITS-1:0] nb_value;

        if (i == DEPTH - 1) begin : g_end
            assign nb_key   = cell_key[i];
            assign nb_value = cell_value[i];
        end else begin : g_mid
            assign nb_key   = cell_key[i+1];
            assign nb_value = cell_value[i+1];
        end

        kvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .IDX        (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .count      (cnt_reg),
            .cmp_key    (s_key),
            .wr_key     (req_key_reg),
            .wr_value   (req_value_reg),
            .nb_key     (nb_key),
            .nb_value   (nb_value),
            .head_key   (cell_key[0]),
            .head_value (cell_value[0]),
            .hit_in     (hit_chain[i]),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .match      (match_vec[i]),
            .hit_out    (hit_chain[i+1])
        );
    end

    assign any_hit = |match_vec;

    // Keys are unique, so at most one cell matches and an OR selects its value.
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_value = hit_value | (cell_value[i] & {VALUE_BITS{match_vec[i]}});
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kvt_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = kvt_pkg::ST_EXEC;
                end
            end
            kvt_pkg::ST_EXEC: begin
                if (func_reg == kvt_pkg::FUNC_LIST && cnt_reg != '0) begin
                    state_next = kvt_pkg::ST_LIST;
                end else if (out_free) begin
                    state_next = kvt_pkg::ST_IDLE;
                end
            end
            kvt_pkg::ST_LIST: begin
                if (out_free && left_reg == CNT_W'(1)) begin
                    state_next = kvt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kvt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        s_tready          = 1'b0;
        cell_ctrl.cmd     = kvt_pkg::CELL_HOLD;
        cell_ctrl.compare = 1'b0;
        cnt_next          = cnt_reg;
        left_next         = left_reg;
        func_next         = func_reg;
        req_key_next      = req_key_reg;
        req_value_next    = req_value_reg;
        out_load          = 1'b0;
        out_status_next   = kvt_pkg::STATUS_DONE;
        out_key_next      = kvt_pkg::KEY_W'(req_key_reg);
        out_value_next    = '0;
        out_count_next    = kvt_pkg::COUNT_W'(cnt_reg);
        out_last_next     = 1'b1;
        case (state_reg)
            kvt_pkg::ST_IDLE: begin
                s_tready          = 1'b1;
                cell_ctrl.compare = s_tvalid;
                if (s_accept) begin
                    func_next      = s_tdata[kvt_pkg::FUNC_W-1:0];
                    req_key_next   = s_key;
                    req_value_next = s_tdata[kvt_pkg::S_VALUE_LSB +: VALUE_BITS];
                end
            end
            kvt_pkg::ST_EXEC: begin
                case (func_reg)
                    kvt_pkg::FUNC_INSERT: begin
                        if (any_hit) begin
                            out_status_next = kvt_pkg::STATUS_EXISTS;
                        end else if (cnt_reg == CNT_W'(DEPTH)) begin
                            out_status_next = kvt_pkg::STATUS_FULL;
                        end else begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    kvt_pkg::FUNC_QUERY: begin
                        if (any_hit) begin
                            out_value_next = kvt_pkg::VALUE_W'(hit_value);
                        end else begin
                            out_status_next = kvt_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    kvt_pkg::FUNC_UPDATE: begin
                        if (!any_hit) begin
                            out_status_next = kvt_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    kvt_pkg::FUNC_DELETE: begin
                        if (any_hit) begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end else begin
                            out_status_next = kvt_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    kvt_pkg::FUNC_LIST: begin
                        out_status_next = kvt_pkg::STATUS_EMPTY;
                        out_key_next    = '0;
                    end
                    default: begin
                    end
                endcase
                out_count_next = kvt_pkg::COUNT_W'(cnt_next);
                if (func_reg == kvt_pkg::FUNC_LIST && cnt_reg != '0) begin
                    // No word here: the list words come from the rotating chain.
                    left_next = cnt_reg;
                    cnt_next  = cnt_reg;
                end else if (out_free) begin
                    out_load = 1'b1;
                    case (func_reg)
                        kvt_pkg::FUNC_INSERT: begin
                            if (!any_hit && cnt_reg != CNT_W'(DEPTH)) begin
                                cell_ctrl.cmd = kvt_pkg::CELL_INSERT;
                            end
                        end
                        kvt_pkg::FUNC_UPDATE: begin
                            if (any_hit) begin
                                cell_ctrl.cmd = kvt_pkg::CELL_UPDATE;
                            end
                        end
                        kvt_pkg::FUNC_DELETE: begin
                            if (any_hit) begin
                                cell_ctrl.cmd = kvt_pkg::CELL_DELETE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    cnt_next = cnt_reg;
                end
            end
            kvt_pkg::ST_LIST: begin
                out_key_next   = kvt_pkg::KEY_W'(cell_key[0]);
                out_value_next = kvt_pkg::VALUE_W'(cell_value[0]);
                out_last_next  = left_reg == CNT_W'(1);
                if (out_free) begin
                    out_load      = 1'b1;
                    cell_ctrl.cmd = kvt_pkg::CELL_ROTATE;
                    left_next     = left_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        req_key_reg   <= req_key_next;
        req_value_reg <= req_value_next;
        left_reg      <= left_next;
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_key_reg    <= out_key_next;
            out_value_reg  <= out_value_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
        if (!aresetn) begin
            state_reg     <= kvt_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_value_reg, out_key_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // The entry count never passes the depth of the chain.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    // Stored keys are unique, so a lookup matches at most one cell.
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kvt_pkg::ST_EXEC |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // A list pass always has words left to send.
    a_list_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kvt_pkg::ST_LIST |-> left_reg != '0)
        else $error("list pass with no entries left");

    // An accepted request puts the controller in the execute state in the following cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == kvt_pkg::ST_EXEC)
        else $error("accepted request not executed");

    // The count only changes when a word is loaded for the receiver.
    a_count_with_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_next != cnt_reg |-> out_load)
        else $error("entry count changed without a result word");

endmodule
